FILE: rtl/core/mtg_pkg.sv
// ----------------------------------------------------------------------------
// MT19937 generator package
// Shared constants, store address type and the command bundle that the
// controller sends to the datapath.
// ----------------------------------------------------------------------------
package mtg_pkg;

   localparam int STATE_WORDS  = 624;
   localparam int TWIST_OFFSET = 397;
   localparam int ADDR_W       = $clog2(STATE_WORDS + 2);
   localparam int WORD_W       = 32;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [WORD_W-1:0] word_type;

   localparam addr_type LAST_ADDR    = addr_type'(STATE_WORDS - 1);
   localparam addr_type POS_EXHAUST  = addr_type'(STATE_WORDS);
   localparam addr_type POS_UNSEEDED = addr_type'(STATE_WORDS + 1);
   localparam addr_type FAR_START    = addr_type'(TWIST_OFFSET);

   localparam word_type TWIST_XOR    = 32'h9908_b0df;
   localparam word_type HIGH_BIT     = 32'h8000_0000;
   localparam word_type LOW_BITS     = 32'h7fff_ffff;
   localparam word_type TEMPER_B     = 32'h9d2c_5680;
   localparam word_type TEMPER_C     = 32'hefc6_0000;
   localparam word_type SEED_MULT    = 32'd6069;
   localparam word_type DEFAULT_SEED = 32'd4357;

   // Request operation codes
   localparam logic OP_DRAW = 1'b0;
   localparam logic OP_SEED = 1'b1;

   // Source of the word written into the store
   typedef enum logic {
      WR_SEED,
      WR_TWIST
   } wsel_type;

   typedef struct packed {
      addr_type rd_a_addr;
      addr_type rd_b_addr;
      logic     wr_en;
      addr_type wr_addr;
      wsel_type wr_sel;
      logic     load_cur;
      logic     seed_load;
      logic     seed_default;
      logic     seed_step;
      logic     out_load;
   } cmd_type;

endpackage

FILE: rtl/core/mtg_datapath.sv
// ----------------------------------------------------------------------------
// MT19937 generator datapath
// Word store with one write and two registered read ports, the seed
// multiplier, the twist combiner and the tempering output register.
// ----------------------------------------------------------------------------
module mtg_datapath
   import mtg_pkg::*;
(
   input  logic     clock,
   input  cmd_type  cmd,
   input  word_type req_seed,
   output word_type rsp_random_word
);

   word_type mem [STATE_WORDS];
   word_type rd_a_ff;
   word_type rd_b_ff;
   word_type cur_ff;
   word_type cur_in;
   word_type prod_ff;
   word_type prod_in;
   word_type out_ff;
   word_type out_in;
   word_type twist_word;
   word_type wr_data;

   function automatic word_type temper(input word_type w);
      word_type y;
      y = w;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   // Twisted word: current word's top bit, next word's low bits, far word.
   always_comb begin
      word_type y;
      y = (cur_ff & HIGH_BIT) | (rd_a_ff & LOW_BITS);
      twist_word = rd_b_ff ^ (y >> 1);
      if (y[0]) begin
         twist_word = twist_word ^ TWIST_XOR;
      end
   end

   assign wr_data = (cmd.wr_sel == WR_TWIST) ? twist_word : prod_ff;

   always_comb begin
      prod_in = prod_ff;
      if (cmd.seed_load) begin
         prod_in = cmd.seed_default ? DEFAULT_SEED : req_seed;
      end else if (cmd.seed_step) begin
         prod_in = word_type'(prod_ff * SEED_MULT);
      end
   end

   assign cur_in = cmd.load_cur ? rd_a_ff : cur_ff;
   assign out_in = cmd.out_load ? temper(rd_a_ff) : out_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[cmd.rd_a_addr];
      rd_b_ff <= mem[cmd.rd_b_addr];
      cur_ff  <= cur_in;
      prod_ff <= prod_in;
      out_ff  <= out_in;
   end

   assign rsp_random_word = out_ff;

endmodule

FILE: rtl/core/mtg_ctrl.sv
// ----------------------------------------------------------------------------
// MT19937 generator controller
// Sequences seeding, the in-place twist and draws, and owns the read
// position and the result valid flag.
// ----------------------------------------------------------------------------
module mtg_ctrl
   import mtg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  logic    req_op,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_TW_PRIME,
      ST_TW_READ,
      ST_TW_WRITE,
      ST_DRAW_READ,
      ST_DRAW_OUT
   } state_type;

   state_type state_ff, state_in;
   addr_type  pos_ff, pos_in;
   addr_type  k_ff, k_in;
   addr_type  far_ff, far_in;
   logic      draw_ff, draw_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      slot_free;
   addr_type  nxt;
   addr_type  far_nxt;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign nxt       = (k_ff == LAST_ADDR) ? '0 : k_ff + addr_type'(1);
   assign far_nxt   = (far_ff == LAST_ADDR) ? '0 : far_ff + addr_type'(1);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      far_in       = far_ff;
      draw_in      = draw_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.wr_sel   = WR_SEED;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               k_in   = '0;
               far_in = FAR_START;
               if (req_op == OP_SEED) begin
                  cmd.seed_load = 1'b1;
                  draw_in       = 1'b0;
                  state_in      = ST_SEED;
               end else if (pos_ff > POS_EXHAUST) begin
                  cmd.seed_load    = 1'b1;
                  cmd.seed_default = 1'b1;
                  draw_in          = 1'b1;
                  state_in         = ST_SEED;
               end else if (pos_ff == POS_EXHAUST) begin
                  state_in = ST_TW_PRIME;
               end else begin
                  state_in = ST_DRAW_READ;
               end
            end
         end
         ST_SEED: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_addr   = k_ff;
            cmd.wr_sel    = WR_SEED;
            cmd.seed_step = 1'b1;
            if (k_ff == LAST_ADDR) begin
               k_in     = '0;
               pos_in   = POS_EXHAUST;
               state_in = draw_ff ? ST_TW_PRIME : ST_IDLE;
            end else begin
               k_in = k_ff + addr_type'(1);
            end
         end
         ST_TW_PRIME: begin
            cmd.rd_a_addr = '0;
            state_in      = ST_TW_READ;
         end
         ST_TW_READ: begin
            cmd.rd_a_addr = nxt;
            cmd.rd_b_addr = far_ff;
            cmd.load_cur  = 1'b1;
            state_in      = ST_TW_WRITE;
         end
         ST_TW_WRITE: begin
            cmd.rd_a_addr = nxt;
            cmd.wr_en     = 1'b1;
            cmd.wr_addr   = k_ff;
            cmd.wr_sel    = WR_TWIST;
            if (k_ff == LAST_ADDR) begin
               pos_in   = '0;
               state_in = ST_DRAW_READ;
            end else begin
               k_in     = nxt;
               far_in   = far_nxt;
               state_in = ST_TW_READ;
            end
         end
         ST_DRAW_READ: begin
            cmd.rd_a_addr = pos_ff;
            state_in      = ST_DRAW_OUT;
         end
         ST_DRAW_OUT: begin
            cmd.rd_a_addr = pos_ff;
            if (slot_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               pos_in       = pos_ff + addr_type'(1);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= POS_UNSEEDED;
         k_ff         <= '0;
         far_ff       <= FAR_START;
         draw_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         k_ff         <= k_in;
         far_ff       <= far_in;
         draw_ff      <= draw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // The read position never goes past the unseeded marker.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_UNSEEDED)
      else $error("read position out of range");

   // A draw on an unseeded store starts the default seeding.
   a_unseeded_draw: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_DRAW && pos_ff == POS_UNSEEDED)
      |=> (state_ff == ST_SEED && draw_ff))
      else $error("unseeded draw did not seed");

   // A result is only loaded when the output register can take it.
   a_out_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> slot_free)
      else $error("result overwrote a pending transfer");

   // The far index tracks the twist index at the fixed offset.
   a_far_offset: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TW_READ || state_ff == ST_TW_WRITE)
      |-> (({1'b0, far_ff} == {1'b0, k_ff} + (ADDR_W+1)'(TWIST_OFFSET)) ||
           ({1'b0, far_ff} + (ADDR_W+1)'(STATE_WORDS - TWIST_OFFSET)
            == {1'b0, k_ff})))
      else $error("twist far index misaligned");

   // A draw is only read from a valid store position.
   a_draw_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAW_READ) |-> (pos_ff < POS_EXHAUST))
      else $error("draw from exhausted position");

endmodule

FILE: rtl/core/mersenne_twister_generator_core.sv
// A draw result is registered through the read and output states after its transfer,
// and the next request is taken once the result is valid; requests stall while busy.
// A draw on an exhausted store first twists the store in place, once per 624 draws.
// A seed writes each of the 624 store words; a draw before any seed seeds by default.
// Reset is synchronous and active high; it marks the store as unseeded and clears
// the result valid flag. The store itself is not cleared.
// ----------------------------------------------------------------------------
// MT19937 generator core
// 32-bit Mersenne Twister with multiplicative seeding, built as a controller
// and a datapath around a 624-word store.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_core
   import mtg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [31:0] req_seed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_random_word
);

   // The controller drives every store access and datapath load through a
   // single command bundle. The store has one write port, so the twist
   // fetches the next and far words in its read state and writes the
   // combined word back in its write state; the current word is carried
   // over from the previous fetch.
   cmd_type cmd;

   mtg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // The datapath holds the store, the seed product register and the
   // tempered output register, which keeps a finished result while the
   // next request transfer is taken.
   mtg_datapath u_datapath (
      .clock           (clock),
      .cmd             (cmd),
      .req_seed        (req_seed),
      .rsp_random_word (rsp_random_word)
   );

endmodule
